// ===== hdl/asp_pkg.sv =====
// Shared types, constants and register codes of the allocation size profiler.
package asp_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 12;
  localparam int unsigned SIZE_BITS_DEF     = 24;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_SIZE_W  = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned KB_W       = 22;
  localparam int unsigned KB_SHIFT   = 10;
  localparam int unsigned OUT_SIZE_W = 24;
  localparam int unsigned LOG2_W     = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [IN_SIZE_W-1:0] BIG_THR_RST     = 24'd2048;
  localparam logic [LOG2_W-1:0]    REPORT_LOG2_RST = 5'd9;
  localparam logic [CNT_W-1:0]     DUMP_THR_RST    = 32'd64;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef enum logic [1:0] {
    REG_TRACE_ENABLE   = 2'd0,
    REG_BIG_THRESHOLD  = 2'd1,
    REG_REPORT_LOG2    = 2'd2,
    REG_DUMP_THRESHOLD = 2'd3
  } asp_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_DUMP  = 2'd2,
    CMD_RSVD  = 2'd3
  } asp_cmd_e;

  typedef struct packed {
    logic                 trace_en;
    logic [IN_SIZE_W-1:0] big_thr;
    logic [LOG2_W-1:0]    rep_log2;
    logic [CNT_W-1:0]     dump_thr;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic eval;
    logic first;
    logic update;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_scan;
    logic cur_alloc;
    logic stall;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ===== hdl/asp_if.sv =====
// Stream interfaces for profiler events and profiler results.
interface asp_in_if;
  logic                            valid;
  logic                            ready;
  logic [asp_pkg::CMD_W-1:0]       command;
  logic [asp_pkg::IN_SIZE_W-1:0]   size;

  modport source (output valid, output command, output size, input ready);
  modport sink   (input valid, input command, input size, output ready);
endinterface

interface asp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [asp_pkg::CNT_W-1:0]       alloc_count;
  logic [asp_pkg::CNT_W-1:0]       free_count;
  logic [asp_pkg::KB_W-1:0]        live_kb;
  logic [asp_pkg::OUT_SIZE_W-1:0]  top_size;
  logic [asp_pkg::CNT_W-1:0]       top_count;
  logic                            report_due;
  logic [asp_pkg::OUT_SIZE_W-1:0]  entry_size;
  logic [asp_pkg::CNT_W-1:0]       entry_hits;
  logic                            last;

  modport source (output valid, output kind, output alloc_count, output free_count,
                  output live_kb, output top_size, output top_count, output report_due,
                  output entry_size, output entry_hits, output last, input ready);
  modport sink   (input valid, input kind, input alloc_count, input free_count,
                  input live_kb, input top_size, input top_count, input report_due,
                  input entry_size, input entry_hits, input last, output ready);
endinterface

// ===== hdl/asp_regs.sv =====
// APB configuration registers of the allocation size profiler.
module asp_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [asp_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [asp_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [asp_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                               pready_o,
  output asp_pkg::cfg_t                      cfg_o
);

  asp_pkg::cfg_t     cfg_q, cfg_d;
  asp_pkg::asp_reg_e reg_idx;
  logic              wr_en;

  assign reg_idx  = asp_pkg::asp_reg_e'(paddr_i[asp_pkg::APB_ADDR_W-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        asp_pkg::REG_TRACE_ENABLE:   cfg_d.trace_en = pwdata_i[0];
        asp_pkg::REG_BIG_THRESHOLD:  cfg_d.big_thr  = pwdata_i[asp_pkg::IN_SIZE_W-1:0];
        asp_pkg::REG_REPORT_LOG2:    cfg_d.rep_log2 = pwdata_i[asp_pkg::LOG2_W-1:0];
        asp_pkg::REG_DUMP_THRESHOLD: cfg_d.dump_thr = pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      asp_pkg::REG_TRACE_ENABLE:   prdata_o = asp_pkg::APB_DATA_W'(cfg_q.trace_en);
      asp_pkg::REG_BIG_THRESHOLD:  prdata_o = asp_pkg::APB_DATA_W'(cfg_q.big_thr);
      asp_pkg::REG_REPORT_LOG2:    prdata_o = asp_pkg::APB_DATA_W'(cfg_q.rep_log2);
      asp_pkg::REG_DUMP_THRESHOLD: prdata_o = cfg_q.dump_thr;
      default:                     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trace_en <= 1'b0;
      cfg_q.big_thr  <= asp_pkg::BIG_THR_RST;
      cfg_q.rep_log2 <= asp_pkg::REPORT_LOG2_RST;
      cfg_q.dump_thr <= asp_pkg::DUMP_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/asp_ctrl.sv =====
// Sequencer of the profiler: accepts events and walks the size table one entry a cycle unless a dump entry stalls it.
module asp_ctrl #(
  parameter int unsigned TABLE_ENTRIES = asp_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  asp_pkg::ctrl_stat_t   stat_i,
  output asp_pkg::ctrl_cmd_t    cmd_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  output logic [IDX_W-1:0]      eval_idx_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIRST  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_FINISH = 5'b10000
  } asp_state_e;

  asp_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_idx;

  assign last_idx   = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign eval_idx_o = idx_q;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    rd_addr_o = idx_q + IDX_W'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.in_scan ? ST_FIRST : ST_FINISH;
        end
      end
      ST_FIRST: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = '0;
        idx_d       = '0;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.eval  = 1'b1;
        cmd_o.first = (idx_q == '0);
        // a dump entry waiting on a full output register holds the scan
        if (!stat_i.stall) begin
          if (last_idx) begin
            state_d = stat_i.cur_alloc ? ST_UPDATE : ST_FINISH;
          end else begin
            cmd_o.rd_en = 1'b1;
            idx_d       = idx_q + IDX_W'(1);
          end
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hdl/asp_datapath.sv =====
// Profiler datapath: counters, repeat-run tracker, size table memory and output register.
module asp_datapath #(
  parameter int unsigned TABLE_ENTRIES = asp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SIZE_BITS     = asp_pkg::SIZE_BITS_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  asp_pkg::cfg_t                      cfg_i,
  input  asp_pkg::ctrl_cmd_t                 cmd_i,
  output asp_pkg::ctrl_stat_t                stat_o,
  input  logic [IDX_W-1:0]                   rd_addr_i,
  input  logic [IDX_W-1:0]                   eval_idx_i,
  input  logic [asp_pkg::CMD_W-1:0]          in_command_i,
  input  logic [asp_pkg::IN_SIZE_W-1:0]      in_size_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_kind_o,
  output logic [asp_pkg::CNT_W-1:0]          out_alloc_count_o,
  output logic [asp_pkg::CNT_W-1:0]          out_free_count_o,
  output logic [asp_pkg::KB_W-1:0]           out_live_kb_o,
  output logic [asp_pkg::OUT_SIZE_W-1:0]     out_top_size_o,
  output logic [asp_pkg::CNT_W-1:0]          out_top_count_o,
  output logic                               out_report_due_o,
  output logic [asp_pkg::OUT_SIZE_W-1:0]     out_entry_size_o,
  output logic [asp_pkg::CNT_W-1:0]          out_entry_hits_o,
  output logic                               out_last_o
);

  localparam int unsigned CW = asp_pkg::CNT_W;
  localparam int unsigned OW = asp_pkg::OUT_SIZE_W;

  // size table
  logic [SIZE_BITS-1:0] size_mem [TABLE_ENTRIES];
  logic [CW-1:0]        hits_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [SIZE_BITS-1:0] rd_size_q;
  logic [CW-1:0]        rd_hits_q;
  logic                 rd_vld_q;

  // event and counters
  logic                 cur_dump_q, cur_alloc_q;
  logic [SIZE_BITS-1:0] sz_q;
  logic [CW-1:0]        alloc_q, free_q, bytes_q, run_count_q;
  logic [SIZE_BITS-1:0] run_size_q;

  // scan results
  logic                 match_q;
  logic [IDX_W-1:0]     match_idx_q, vic_idx_q;
  logic [CW-1:0]        match_hits_q, vic_hits_q;

  // result waiting to go out
  logic                 pend_kind_q;
  logic [SIZE_BITS-1:0] pend_size_q;
  logic [CW-1:0]        pend_hits_q;

  // output register
  logic                 out_valid_q;
  logic                 out_kind_q, out_due_q, out_last_q;
  logic [CW-1:0]        out_alloc_q, out_free_q, out_top_count_q, out_hits_q;
  logic [asp_pkg::KB_W-1:0] out_kb_q;
  logic [OW-1:0]        out_top_size_q, out_entry_size_q;

  asp_pkg::asp_cmd_e    in_cmd;
  logic [SIZE_BITS-1:0] in_sz, e_size;
  logic [CW-1:0]        e_hits, new_hits, due_mask, run32, pend32;
  logic [IDX_W-1:0]     wr_idx;
  logic                 in_dump, in_alloc, in_free;
  logic                 qual, out_free, stall, do_eval, emit_eval, out_load;
  logic                 due;

  assign in_cmd   = asp_pkg::asp_cmd_e'(in_command_i);
  assign in_sz    = SIZE_BITS'(in_size_i);
  assign in_dump  = (in_cmd == asp_pkg::CMD_DUMP);
  assign in_alloc = cfg_i.trace_en && (in_cmd == asp_pkg::CMD_ALLOC) && (in_sz != '0);
  assign in_free  = cfg_i.trace_en && (in_cmd == asp_pkg::CMD_FREE);

  assign e_size = rd_vld_q ? rd_size_q : '0;
  assign e_hits = rd_vld_q ? rd_hits_q : '0;
  assign qual   = (e_hits > cfg_i.dump_thr);

  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = cur_dump_q && qual && !out_free;
  assign do_eval   = cmd_i.eval && !stall;
  assign emit_eval = do_eval && cur_dump_q && qual;
  assign out_load  = emit_eval || cmd_i.finish;

  assign stat_o.in_scan   = in_dump || in_alloc;
  assign stat_o.cur_alloc = cur_alloc_q;
  assign stat_o.stall     = stall;
  assign stat_o.out_free  = out_free;

  assign new_hits = match_q ? (match_hits_q + CW'(1)) : CW'(1);
  assign wr_idx   = match_q ? match_idx_q : vic_idx_q;
  assign due_mask = ~({CW{1'b1}} << cfg_i.rep_log2);
  assign due      = cur_alloc_q && ((alloc_q & due_mask) == '0);
  assign run32    = CW'(run_size_q);
  assign pend32   = CW'(pend_size_q);

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      size_mem[wr_idx] <= sz_q;
      hits_mem[wr_idx] <= new_hits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_size_q <= size_mem[rd_addr_i];
      rd_hits_q <= hits_mem[rd_addr_i];
      rd_vld_q  <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // event capture and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dump_q  <= 1'b0;
      cur_alloc_q <= 1'b0;
      pend_kind_q <= asp_pkg::KIND_STATUS;
      alloc_q     <= '0;
      free_q      <= '0;
      bytes_q     <= '0;
      run_size_q  <= '0;
      run_count_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        cur_dump_q  <= in_dump;
        cur_alloc_q <= in_alloc;
        pend_kind_q <= asp_pkg::KIND_STATUS;
        if (in_free) begin
          free_q <= free_q + CW'(1);
        end
      end
      if (emit_eval) begin
        pend_kind_q <= asp_pkg::KIND_ENTRY;
      end
      if (cmd_i.update) begin
        alloc_q <= alloc_q + CW'(1);
        bytes_q <= bytes_q + CW'(sz_q);
        if (CW'(sz_q) >= CW'(cfg_i.big_thr)) begin
          if (sz_q == run_size_q) begin
            run_count_q <= run_count_q + CW'(1);
          end else begin
            run_size_q  <= sz_q;
            run_count_q <= CW'(1);
          end
        end
      end
    end
  end

  // scan bookkeeping and dump entry capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sz_q <= in_sz;
    end
    if (emit_eval) begin
      pend_size_q <= e_size;
      pend_hits_q <= e_hits;
    end
    if (do_eval && cur_alloc_q) begin
      if (cmd_i.first) begin
        match_q      <= (e_size == sz_q);
        match_idx_q  <= eval_idx_i;
        match_hits_q <= e_hits;
        vic_idx_q    <= eval_idx_i;
        vic_hits_q   <= e_hits;
      end else if (!match_q) begin
        if (e_size == sz_q) begin
          match_q      <= 1'b1;
          match_idx_q  <= eval_idx_i;
          match_hits_q <= e_hits;
        end else if (e_hits < vic_hits_q) begin
          vic_idx_q  <= eval_idx_i;
          vic_hits_q <= e_hits;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.finish;
      if (pend_kind_q == asp_pkg::KIND_STATUS) begin
        out_alloc_q      <= alloc_q;
        out_free_q       <= free_q;
        out_kb_q         <= bytes_q[CW-1:asp_pkg::KB_SHIFT];
        out_top_size_q   <= run32[OW-1:0];
        out_top_count_q  <= run_count_q;
        out_due_q        <= due;
        out_entry_size_q <= '0;
        out_hits_q       <= '0;
      end else begin
        out_alloc_q      <= '0;
        out_free_q       <= '0;
        out_kb_q         <= '0;
        out_top_size_q   <= '0;
        out_top_count_q  <= '0;
        out_due_q        <= 1'b0;
        out_entry_size_q <= pend32[OW-1:0];
        out_hits_q       <= pend_hits_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_alloc_count_o = out_alloc_q;
  assign out_free_count_o  = out_free_q;
  assign out_live_kb_o     = out_kb_q;
  assign out_top_size_o    = out_top_size_q;
  assign out_top_count_o   = out_top_count_q;
  assign out_report_due_o  = out_due_q;
  assign out_entry_size_o  = out_entry_size_q;
  assign out_entry_hits_o  = out_hits_q;
  assign out_last_o        = out_last_q;

  // table entries never lose their valid bit
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(valid_q) & ~valid_q) == '0))
    else $error("size table valid bit cleared");

  a_alloc_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(alloc_q) |-> $past(cmd_i.update))
    else $error("alloc counter moved outside a table update");

  a_free_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(free_q) |-> $past(cmd_i.accept && in_free))
    else $error("free counter moved without a free transaction");

  a_update_is_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (cur_alloc_q && !cur_dump_q))
    else $error("table update outside an allocation");

endmodule

// ===== hdl/alloc_size_profiler.sv =====
// Top level of the allocation size profiler: config port, sequencer and datapath.
//
// Each event transaction runs to completion before the next is taken. A free, a
// reserved command, a disabled event or a zero-size allocation goes from accept
// straight to the finish state. An allocation and a dump walk the size table
// through its single read port, one entry per cycle; an allocation then passes
// through an update state before finishing. Every event also waits in its finish
// state while the previous result still sits unaccepted in the output register.
// A dump additionally waits on each entry the sink holds off. Results leave
// through an output register. A dump gives its status result first and then the
// entries above dump_threshold in table order, last marked.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 of the APB port and
// must be written only while the block is idle.
module alloc_size_profiler #(
  parameter int unsigned TABLE_ENTRIES = asp_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SIZE_BITS     = asp_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [asp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [asp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [asp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  asp_in_if.sink                             in_if,
  asp_out_if.source                          out_if
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  asp_pkg::cfg_t       cfg;
  asp_pkg::ctrl_cmd_t  cmd;
  asp_pkg::ctrl_stat_t stat;
  logic [IDX_W-1:0]    rd_addr, eval_idx;

  asp_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  asp_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .eval_idx_o (eval_idx)
  );

  asp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SIZE_BITS     (SIZE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .rd_addr_i         (rd_addr),
    .eval_idx_i        (eval_idx),
    .in_command_i      (in_if.command),
    .in_size_i         (in_if.size),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .out_kind_o        (out_if.kind),
    .out_alloc_count_o (out_if.alloc_count),
    .out_free_count_o  (out_if.free_count),
    .out_live_kb_o     (out_if.live_kb),
    .out_top_size_o    (out_if.top_size),
    .out_top_count_o   (out_if.top_count),
    .out_report_due_o  (out_if.report_due),
    .out_entry_size_o  (out_if.entry_size),
    .out_entry_hits_o  (out_if.entry_hits),
    .out_last_o        (out_if.last)
  );

endmodule

// ===== bench/alloc_size_profiler_test.sv =====
// Self-checking testbench of the allocation size profiler: stream driver, monitor and predictor.
module alloc_size_profiler_test;
  import asp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef struct {
    asp_cmd_e              cmd;
    logic [IN_SIZE_W-1:0]  size;
  } event_t;

  typedef struct packed {
    logic                  kind;
    logic [CNT_W-1:0]      allocs;
    logic [CNT_W-1:0]      frees;
    logic [KB_W-1:0]       kb;
    logic [OUT_SIZE_W-1:0] top_size;
    logic [CNT_W-1:0]      top_count;
    logic                  due;
    logic [OUT_SIZE_W-1:0] ent_size;
    logic [CNT_W-1:0]      ent_hits;
    logic                  last;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  asp_in_if  ev_if ();
  asp_out_if rep_if ();

  alloc_size_profiler i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (ev_if),
    .out_if  (rep_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the profile state and registers
  logic [IN_SIZE_W-1:0] size_tbl [N_ENTRIES] = '{default: '0};
  logic [CNT_W-1:0]     hits_tbl [N_ENTRIES] = '{default: '0};
  logic [CNT_W-1:0]     n_allocs = '0;
  logic [CNT_W-1:0]     n_frees  = '0;
  logic [CNT_W-1:0]     byte_sum = '0;
  logic [IN_SIZE_W-1:0] run_sz   = '0;
  logic [CNT_W-1:0]     run_len  = '0;
  logic                 trace_on = 1'b0;
  logic [IN_SIZE_W-1:0] big_thr  = BIG_THR_RST;
  logic [LOG2_W-1:0]    rep_log2 = REPORT_LOG2_RST;
  logic [CNT_W-1:0]     dump_thr = DUMP_THR_RST;

  event_t  event_q [$];
  report_t report_q [$];
  int      errors = 0;
  bit      in_took = 1'b0;
  bit      steady = 1'b0;
  logic [IN_SIZE_W-1:0] size_pool [6];
  logic [IN_SIZE_W-1:0] prev_size = '0;

  function automatic string show(input report_t r);
    return $sformatf({"kind=%0d allocs=%0d frees=%0d kb=%0d top=%0h/%0d due=%0d ",
                      "entry=%0h/%0d last=%0d"},
                     r.kind, r.allocs, r.frees, r.kb, r.top_size, r.top_count, r.due,
                     r.ent_size, r.ent_hits, r.last);
  endfunction

  task automatic profile_event(input asp_cmd_e cmd, input logic [IN_SIZE_W-1:0] sz);
    report_t r;
    logic [CNT_W-1:0] mask;
    logic due;
    bit found;
    int victim;
    int n_dump;
    int n_shown;
    due = 1'b0;
    n_dump = 0;
    if (cmd == CMD_DUMP) begin
      foreach (hits_tbl[i]) if (hits_tbl[i] > dump_thr) n_dump++;
    end else if (trace_on && cmd == CMD_FREE) begin
      n_frees = n_frees + 1;
    end else if (trace_on && cmd == CMD_ALLOC && sz != '0) begin
      n_allocs = n_allocs + 1;
      // first match gains a hit, else first entry with fewest hits is replaced
      found = 1'b0;
      victim = 0;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!found) begin
          if (size_tbl[i] == sz) begin
            hits_tbl[i] = hits_tbl[i] + 1;
            found = 1'b1;
          end else if (hits_tbl[i] < hits_tbl[victim]) begin
            victim = i;
          end
        end
      end
      if (!found) begin
        size_tbl[victim] = sz;
        hits_tbl[victim] = 1;
      end
      byte_sum = byte_sum + CNT_W'(sz);
      if (sz >= big_thr) begin
        if (sz == run_sz) begin
          run_len = run_len + 1;
        end else begin
          run_sz = sz;
          run_len = 1;
        end
      end
      mask = CNT_W'((64'd1 << rep_log2) - 64'd1);
      due = ((n_allocs & mask) == '0);
    end
    r = '0;
    r.kind = KIND_STATUS;
    r.allocs = n_allocs;
    r.frees = n_frees;
    r.kb = byte_sum[KB_SHIFT +: KB_W];
    r.top_size = run_sz;
    r.top_count = run_len;
    r.due = due;
    r.last = (n_dump == 0);
    report_q.push_back(r);
    if (cmd == CMD_DUMP) begin
      n_shown = 0;
      foreach (hits_tbl[i]) begin
        if (hits_tbl[i] > dump_thr) begin
          n_shown++;
          r = '0;
          r.kind = KIND_ENTRY;
          r.ent_size = size_tbl[i];
          r.ent_hits = hits_tbl[i];
          r.last = (n_shown == n_dump);
          report_q.push_back(r);
        end
      end
    end
  endtask

  // event driver
  always @(negedge clk_i) begin
    event_t nxt;
    if (!ev_if.valid || in_took) begin
      if (event_q.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
        nxt = event_q.pop_front();
        ev_if.valid <= 1'b1;
        ev_if.command <= nxt.cmd;
        ev_if.size <= nxt.size;
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) rep_if.ready <= steady || ($urandom_range(99) >= 29);

  // monitor: predict on each accepted event, check each accepted result
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    in_took = rst_ni && ev_if.valid && ev_if.ready;
    if (in_took) profile_event(asp_cmd_e'(ev_if.command), ev_if.size);
    if (rst_ni && rep_if.valid && rep_if.ready) begin
      got.kind = rep_if.kind;
      got.allocs = rep_if.alloc_count;
      got.frees = rep_if.free_count;
      got.kb = rep_if.live_kb;
      got.top_size = rep_if.top_size;
      got.top_count = rep_if.top_count;
      got.due = rep_if.report_due;
      got.ent_size = rep_if.entry_size;
      got.ent_hits = rep_if.entry_hits;
      got.last = rep_if.last;
      if (report_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result %s", $realtime, show(got));
      end else begin
        want = report_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (event_q.size() != 0 || ev_if.valid || report_q.size() != 0);
    // idle margin before the registers are rewritten
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_put(input asp_reg_e idx, input logic [APB_DATA_W-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    case (idx)
      REG_TRACE_ENABLE:   trace_on = v[0];
      REG_BIG_THRESHOLD:  big_thr = v[IN_SIZE_W-1:0];
      REG_REPORT_LOG2:    rep_log2 = v[LOG2_W-1:0];
      REG_DUMP_THRESHOLD: dump_thr = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_event(input asp_cmd_e cmd, input logic [IN_SIZE_W-1:0] sz);
    event_t e;
    e.cmd = cmd;
    e.size = sz;
    event_q.push_back(e);
  endtask

  // mostly allocs from a small size pool so hits build up and large runs repeat
  task automatic add_random_event();
    int pick;
    int sel;
    logic [IN_SIZE_W-1:0] sz;
    pick = $urandom_range(99);
    sel = $urandom_range(99);
    if (sel < 25) sz = prev_size;
    else if (sel < 65) sz = size_pool[$urandom_range(5)];
    else if (sel < 70) sz = '0;
    else if (sel < 74) sz = '1;
    else sz = IN_SIZE_W'($urandom);
    if (pick < 8) begin
      add_event(CMD_DUMP, IN_SIZE_W'($urandom));
    end else if (pick < 20) begin
      add_event(CMD_FREE, IN_SIZE_W'($urandom));
    end else if (pick < 23) begin
      add_event(CMD_RSVD, IN_SIZE_W'($urandom));
    end else begin
      add_event(CMD_ALLOC, sz);
      prev_size = sz;
    end
  endtask

  task automatic run_phase(input logic tr, input logic [IN_SIZE_W-1:0] big,
                           input logic [LOG2_W-1:0] lg, input logic [CNT_W-1:0] dth,
                           input int n, input bit calm);
    settle();
    apb_put(REG_TRACE_ENABLE, APB_DATA_W'(tr));
    apb_put(REG_BIG_THRESHOLD, APB_DATA_W'(big));
    apb_put(REG_REPORT_LOG2, APB_DATA_W'(lg));
    apb_put(REG_DUMP_THRESHOLD, dth);
    steady = calm;
    size_pool[0] = big;
    size_pool[1] = big - 1'b1;
    size_pool[2] = IN_SIZE_W'($urandom_range(1, 255));
    size_pool[3] = IN_SIZE_W'($urandom_range(256, 8191));
    size_pool[4] = IN_SIZE_W'($urandom_range(1, 24'hFFFFFF));
    size_pool[5] = IN_SIZE_W'($urandom_range(1000, 3000));
    repeat (n) add_random_event();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ev_if.valid = 1'b0;
    ev_if.command = CMD_ALLOC;
    ev_if.size = '0;
    rep_if.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // tracing is off after reset: nothing may count
    add_event(CMD_ALLOC, 24'd5);
    add_event(CMD_FREE, 24'hFFFFFF);
    add_event(CMD_RSVD, 24'd5);
    add_event(CMD_DUMP, 24'd0);

    run_phase(1'b1, 24'd2048, 5'd0, 32'd0, 0, 1'b0);
    add_event(CMD_ALLOC, 24'd0);
    add_event(CMD_ALLOC, 24'hFFFFFF);
    add_event(CMD_ALLOC, 24'hFFFFFF);
    add_event(CMD_ALLOC, 24'd2048);
    add_event(CMD_ALLOC, 24'd2047);
    add_event(CMD_ALLOC, 24'd1);
    add_event(CMD_FREE, 24'hFFFFFF);
    add_event(CMD_RSVD, 24'hFFFFFF);
    add_event(CMD_DUMP, 24'hFFFFFF);
    add_event(CMD_ALLOC, 24'd2048);
    add_event(CMD_ALLOC, 24'd2048);
    add_event(CMD_DUMP, 24'd0);

    run_phase(1'b1, 24'd2048, 5'd0, 32'd0, 60, 1'b1);
    run_phase(1'b1, 24'd0, 5'd3, 32'd2, 70, 1'b0);
    run_phase(1'b1, 24'hFFFFFF, 5'd31, 32'hFFFFFFFF, 50, 1'b0);
    run_phase(1'b1, 24'd5000, 5'd1, 32'd5, 70, 1'b0);
    run_phase(1'b0, 24'd300, 5'd2, 32'd1, 30, 1'b0);
    run_phase(1'b1, 24'd100, 5'd4, 32'd1, 70, 1'b0);
    settle();

    if (errors == 0 && report_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
